>>> hw/rtl/mtp_pkg.sv
// ----------------------------------------------------------------------------
// mtp_pkg - shared constants and functions for the MT19937 generator
// Word count, tap offset, seeding multiplier, twist and tempering functions.
// ----------------------------------------------------------------------------
package mtp_pkg;

    localparam int STATE_WORDS = 624;
    localparam int TAP_OFFSET  = 397;
    localparam int IDX_W       = $clog2(STATE_WORDS);

    localparam logic [31:0] SEED_MULT = 32'd1812433253;
    localparam logic [31:0] TWIST_XOR = 32'h9908_b0df;
    localparam logic [31:0] TEMPER_B  = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C  = 32'hefc6_0000;

    // one twist step: high bit of cur, low bits of the next word, tap word
    function automatic logic [31:0] twist_one(input logic [31:0] cur,
                                              input logic [31:0] nxt,
                                              input logic [31:0] tap);
        logic [31:0] y;
        logic [31:0] r;
        y = {cur[31], nxt[30:0]};
        r = tap ^ (y >> 1);
        if (y[0]) begin
            r = r ^ TWIST_XOR;
        end
        return r;
    endfunction

    function automatic logic [31:0] temper(input logic [31:0] y_in);
        logic [31:0] y;
        y = y_in;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

>>> hw/rtl/mersenne_twister_prng.sv
// ----------------------------------------------------------------------------
// mersenne_twister_prng - 32-bit MT19937 generator
// State words in a 624 x 32 RAM, twisted in place one word per draw.
// ----------------------------------------------------------------------------
// Usage: raise start with i_kind = 0 to reseed from i_seed, or i_kind = 1 to
// draw one word. A beat is taken on a clock edge where start is high and busy
// is low. A draw holds busy for one cycle; its tempered word shows on
// o_random_word with o_valid high for exactly one cycle, starting at the edge
// after the accepting edge and taken on the edge after that, and a new beat
// can be taken on that same edge. The pace is set by the registered reads
// of the state RAM. A reseed gives no output and holds busy while each of
// the 623 derived words passes through a multiply state and an add/write
// state of the seeding recurrence. The receiver cannot stall:
// capture o_random_word whenever o_valid is high. Draws before the first
// reseed return unspecified words.
// ----------------------------------------------------------------------------
module mersenne_twister_prng
    import mtp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [31:0] i_seed,
    output logic        o_valid,
    output logic [31:0] o_random_word
);

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0] TAP_IDX   = IDX_W'(TAP_OFFSET);
    localparam logic [IDX_W-1:0] WORDS_IDX = IDX_W'(STATE_WORDS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEED_MUL,
        S_SEED_ADD,
        S_DRAW
    } t_state;

    t_state            r_state;
    logic [IDX_W-1:0]  r_idx;       // draw index, or word count while seeding
    logic [31:0]       r_prev;      // previous seed word
    logic [31:0]       r_prod;      // registered seed product
    logic [31:0]       r_cur;       // word at r_idx, not yet twisted
    logic [31:0]       r_rd_nxt;
    logic [31:0]       r_rd_tap;
    logic              r_valid;
    logic [31:0]       r_word;

    logic [31:0]       r_mem [STATE_WORDS];

    logic              accept;
    logic [IDX_W-1:0]  addr_nxt;
    logic [IDX_W-1:0]  tap_sum;
    logic [IDX_W-1:0]  addr_tap;
    logic [31:0]       seed_mix;
    logic [31:0]       seed_word;
    logic [31:0]       twisted;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [31:0]       wdata;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // read addresses follow the draw index: next word and the tap word
    assign addr_nxt = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
    assign tap_sum  = r_idx + TAP_IDX;
    assign addr_tap = (tap_sum >= WORDS_IDX) ? tap_sum - WORDS_IDX : tap_sum;

    assign seed_mix  = r_prev ^ (r_prev >> 30);
    assign seed_word = r_prod + 32'(r_idx);
    assign twisted   = twist_one(r_cur, r_rd_nxt, r_rd_tap);

    // single write port: seed word 0, derived seed words, twisted word
    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = twisted;
        unique case (r_state)
            S_IDLE: begin
                if (accept && !i_kind) begin
                    we    = 1'b1;
                    waddr = '0;
                    wdata = i_seed;
                end
            end
            S_SEED_ADD: begin
                we    = 1'b1;
                wdata = seed_word;
            end
            S_DRAW: begin
                we = 1'b1;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // state RAM: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd_nxt <= r_mem[addr_nxt];
        r_rd_tap <= r_mem[addr_tap];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_kind) begin
                            r_state <= S_DRAW;
                        end else begin
                            r_prev  <= i_seed;
                            r_cur   <= i_seed;
                            r_idx   <= IDX_W'(1);
                            r_state <= S_SEED_MUL;
                        end
                    end
                end
                S_SEED_MUL: begin
                    r_prod  <= SEED_MULT * seed_mix;
                    r_state <= S_SEED_ADD;
                end
                S_SEED_ADD: begin
                    r_prev <= seed_word;
                    if (r_idx == LAST_IDX) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SEED_MUL;
                    end
                end
                S_DRAW: begin
                    // next word becomes current; it is untouched until then
                    r_cur   <= r_rd_nxt;
                    r_word  <= temper(twisted);
                    r_valid <= 1'b1;
                    r_idx   <= addr_nxt;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_valid;
    assign o_random_word = r_word;

    // a result beat only follows a draw cycle
    a_valid_after_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_DRAW))
        else $error("result beat without a draw");

    // an accepted beat always makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // index stays inside the state RAM
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_IDX)
        else $error("word index out of range");

    // seeding never rewrites word 0, which holds the seed itself
    a_seed_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEED_ADD) |-> (r_idx != '0))
        else $error("seed write hit word 0");

    // a draw cycle lasts exactly one cycle
    a_draw_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAW) |=> (r_state == S_IDLE) && o_valid)
        else $error("draw did not complete in one cycle");

endmodule

>>> sim/mtp_tb_pkg.sv
// ----------------------------------------------------------------------------
// mtp_tb_pkg - shared codes for the MT19937 generator testbench
// Beat kinds, used by both the stimulus side and the checker.
// ----------------------------------------------------------------------------
package mtp_tb_pkg;

    typedef enum logic {
        KIND_RESEED = 1'b0,
        KIND_DRAW   = 1'b1
    } beat_kind_e;

endpackage

>>> sim/mtp_checker.sv
// ----------------------------------------------------------------------------
// mtp_checker - scoreboard for the MT19937 generator
// Watches the command and result ports, keeps its own copy of the 624-word
// pool, queues the tempered word owed for each draw and compares in order.
// ----------------------------------------------------------------------------
module mtp_checker
    import mtp_pkg::*, mtp_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_kind,
    input  logic [31:0] i_seed,
    input  logic        i_valid,
    input  logic [31:0] i_random_word,
    output int          o_fail_count,
    output int          o_words_owed
);

    localparam logic [31:0] INIT_MULT   = 32'd1812433253;
    localparam logic [31:0] TWIST_CONST = 32'h9908_b0df;
    localparam logic [31:0] MASK_B      = 32'h9d2c_5680;
    localparam logic [31:0] MASK_C      = 32'hefc6_0000;

    logic [31:0] pool [STATE_WORDS];
    int unsigned pool_pos;
    logic [31:0] owed_words [$];
    logic [31:0] want;

    task automatic flag(input string what, input logic [31:0] got,
                        input logic [31:0] exp_word);
        o_fail_count++;
        $display("MISMATCH %s: got %h, want %h at %0t", what, got, exp_word, $time);
    endtask

    function automatic void seed_pool(input logic [31:0] s);
        logic [31:0] p;
        pool[0] = s;
        for (int i = 1; i < STATE_WORDS; i++) begin
            p       = pool[i-1];
            pool[i] = INIT_MULT * (p ^ (p >> 30)) + 32'(i);
        end
        pool_pos = STATE_WORDS;
    endfunction

    // full in-place regeneration; later words see already-updated neighbors
    function automatic void regen_pool();
        logic [31:0] mixed;
        logic [31:0] fresh;
        for (int k = 0; k < STATE_WORDS; k++) begin
            mixed = {pool[k][31], pool[(k + 1) % STATE_WORDS][30:0]};
            fresh = pool[(k + TAP_OFFSET) % STATE_WORDS] ^ (mixed >> 1);
            if (mixed[0]) begin
                fresh = fresh ^ TWIST_CONST;
            end
            pool[k] = fresh;
        end
        pool_pos = 0;
    endfunction

    function automatic logic [31:0] scramble(input logic [31:0] w);
        logic [31:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & MASK_B);
        y = y ^ ((y << 15) & MASK_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic [31:0] next_word();
        logic [31:0] raw;
        if (pool_pos >= STATE_WORDS) begin
            regen_pool();
        end
        raw = pool[pool_pos];
        pool_pos++;
        return scramble(raw);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (pool[i]) pool[i] = '0;
            pool_pos = STATE_WORDS;
            owed_words.delete();
        end else begin
            // results first: a beat taken on this edge cannot answer yet
            if (i_valid === 1'b1) begin
                if (owed_words.size() == 0) begin
                    flag("unexpected word", i_random_word, 'x);
                end else begin
                    want = owed_words.pop_front();
                    if (i_random_word !== want) begin
                        flag("random_word", i_random_word, want);
                    end
                end
            end else if (i_valid !== 1'b0) begin
                flag("o_valid unknown", i_random_word, 'x);
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                if (i_kind == KIND_RESEED) begin
                    seed_pool(i_seed);
                end else begin
                    owed_words.push_back(next_word());
                end
            end
        end
        o_words_owed = owed_words.size();
    end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench - top level for the MT19937 generator
// Drives reseed and draw beats with random idle gaps, lets the checker
// predict and compare every word, and prints the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import mtp_tb_pkg::*;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        i_kind  = KIND_DRAW;
    logic [31:0] i_seed  = '0;
    logic        busy;
    logic        o_valid;
    logic [31:0] o_random_word;

    int fail_count;
    int words_owed;

    // chance in percent that the sender holds off before a beat
    int idle_pct = 13;

    always #1 i_clk = ~i_clk;

    mersenne_twister_prng dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_seed        (i_seed),
        .o_valid       (o_valid),
        .o_random_word (o_random_word)
    );

    mtp_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_kind        (i_kind),
        .i_seed        (i_seed),
        .i_valid       (o_valid),
        .i_random_word (o_random_word),
        .o_fail_count  (fail_count),
        .o_words_owed  (words_owed)
    );

    // Present one beat. Called at a falling edge, returns at a falling edge
    // after the beat was taken, so start stays high between back-to-back
    // beats and is written once per step.
    task automatic send_beat(input beat_kind_e kind, input logic [31:0] seed);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_kind <= kind;
        i_seed <= seed;
        // taken on the first rising edge with busy low
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        // reset: held, then released at a falling edge
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed ---
        // zero seed; draw seed fields carry extremes that must be ignored
        send_beat(KIND_RESEED, 32'h0000_0000);
        send_beat(KIND_DRAW,   32'h0000_0000);
        send_beat(KIND_DRAW,   32'hffff_ffff);
        send_beat(KIND_DRAW,   32'ha5a5_a5a5);
        // all-ones seed, reseed in the middle of a round
        send_beat(KIND_RESEED, 32'hffff_ffff);
        send_beat(KIND_DRAW,   32'h5a5a_5a5a);
        send_beat(KIND_DRAW,   32'h0000_0000);
        // back-to-back reseeds: only the second one may count
        send_beat(KIND_RESEED, 32'd5489);
        send_beat(KIND_RESEED, 32'h8000_0000);
        send_beat(KIND_DRAW,   32'hffff_ffff);
        send_beat(KIND_DRAW,   32'h0000_0001);
        send_beat(KIND_DRAW,   32'h7fff_ffff);
        // classic default seed, then seed of one
        send_beat(KIND_RESEED, 32'd5489);
        send_beat(KIND_DRAW,   32'h0000_0000);
        send_beat(KIND_DRAW,   32'h0000_0000);
        send_beat(KIND_RESEED, 32'h0000_0001);
        send_beat(KIND_DRAW,   32'hffff_ffff);

        // --- long draw run, no idling ---
        // runs past word 227, where the tap starts landing on words already
        // twisted in this round
        idle_pct = 0;
        send_beat(KIND_RESEED, $urandom());
        repeat (330) send_beat(KIND_DRAW, $urandom());
        idle_pct = 13;

        // --- random mix ---
        // mostly draws with garbage seed fields, an occasional reseed
        repeat (45) begin
            if ($urandom_range(99) < 4) begin
                send_beat(KIND_RESEED, $urandom());
            end else begin
                send_beat(KIND_DRAW, $urandom());
            end
        end
        // end on draws so the last beat owes a word
        repeat (8) send_beat(KIND_DRAW, $urandom());
        start <= 1'b0;

        // drain, then give a reseed's worth of cycles for stray words
        while (words_owed != 0) @(negedge i_clk);
        repeat (1300) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("mersenne_twister_prng verification clean");
        end else begin
            $display("mersenne_twister_prng verification failed");
        end
        $finish;
    end

    // watchdog: several times the slowest legal run
    initial begin : watchdog
        #800_000;
        $display("mersenne_twister_prng verification failed");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/mtp_pkg.sv
hw/rtl/mersenne_twister_prng.sv
sim/mtp_tb_pkg.sv
sim/mtp_checker.sv
sim/testbench.sv
